// ----- rtl/htf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htf_pkg
// Types, constants and table functions shared by the header field tokenizer.
// ----------------------------------------------------------------------------
package htf_pkg;

  // configuration register indexes
  typedef enum logic {
    CFG_MAX_LINE_BYTES = 1'b0,
    CFG_MAX_FIELDS     = 1'b1
  } cfg_idx_e;

  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned LINE_CNT_W      = 16;
  localparam int unsigned FIELD_CNT_W     = 10;
  localparam logic [LINE_CNT_W-1:0]  DEF_LINE_BYTES = 16'd8190;
  localparam logic [FIELD_CNT_W-1:0] DEF_FIELDS     = 10'd100;
  localparam logic [7:0] FOLD_BYTE = 8'h20;

  // request queue between classifier and automaton
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CLS_INVALID = 3'd0,
    CLS_VISIBLE = 3'd1,
    CLS_COLON   = 3'd2,
    CLS_TOKEN   = 3'd3,
    CLS_BLANK   = 3'd4,
    CLS_CR      = 3'd5,
    CLS_LF      = 3'd6
  } cls_e;

  typedef enum logic [3:0] {
    ST_FAILED       = 4'd0,
    ST_LINE_START   = 4'd1,
    ST_NAME         = 4'd2,
    ST_VALUE_LEAD   = 4'd3,
    ST_VALUE        = 4'd4,
    ST_EXPECT_LF    = 4'd5,
    ST_LINE_END     = 4'd6,
    ST_EXPECT_END_LF = 4'd7,
    ST_DONE         = 4'd8
  } state_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_NAME    = 3'd1,
    ACT_VALUE   = 3'd2,
    ACT_HOLD_WS = 3'd3,
    ACT_FOLD    = 3'd4,
    ACT_COMMIT  = 3'd5
  } act_e;

  typedef enum logic [2:0] {
    TK_NONE    = 3'd0,
    TK_NAME    = 3'd1,
    TK_VALUE   = 3'd2,
    TK_HOLD_WS = 3'd3,
    TK_FOLD    = 3'd4
  } tk_e;

  typedef enum logic [2:0] {
    STAT_IN_PROGRESS = 3'd0,
    STAT_COMPLETE    = 3'd1,
    STAT_MALFORMED   = 3'd2,
    STAT_LINE_LONG   = 3'd3,
    STAT_TOO_MANY    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FC_NONE      = 2'd0,
    FC_MALFORMED = 2'd1,
    FC_LINE_LONG = 2'd2,
    FC_TOO_MANY  = 2'd3
  } fcause_e;

  typedef struct packed {
    logic [7:0] octet;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    tk_e        token_kind;
    logic [7:0] token_byte;
    logic       field_end;
    status_e    status;
  } out_item_t;

  // classified request as it sits in the queue
  typedef struct packed {
    logic       restart;
    cls_e       cls;
    logic [7:0] octet;
    logic [7:0] octet_lc;
  } q_item_t;

  typedef struct packed {
    act_e   act;
    state_e nxt;
  } trans_t;

  // 3-bit class per byte 0..127 in a nibble each, eight per word, first byte in the top nibble
  localparam logic [31:0] CLASS_WORDS [16] = '{
    32'h00000000, 32'h04600500, 32'h00000000, 32'h00000000,
    32'h43133333, 32'h11331331, 32'h33333333, 32'h33211111,
    32'h13333333, 32'h33333333, 32'h33333333, 32'h33311133,
    32'h33333333, 32'h33333333, 32'h33333333, 32'h33313130
  };

  function automatic cls_e byte_class(input logic [7:0] b);
    logic [31:0] w;
    logic [2:0]  c;
    w = CLASS_WORDS[b[6:3]];
    c = w[{~b[2:0], 2'b00} +: 3];
    if (b[7]) begin
      return CLS_INVALID;
    end
    return cls_e'(c);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? (b + 8'h20) : b;
  endfunction

  // next state ST_FAILED means the byte is malformed here
  function automatic trans_t trans(input state_e st, input cls_e c);
    trans_t e;
    e = '{act: ACT_NONE, nxt: ST_FAILED};
    case (st)
      ST_LINE_START: begin
        case (c)
          CLS_TOKEN: e = '{act: ACT_NAME, nxt: ST_NAME};
          CLS_CR:    e = '{act: ACT_NONE, nxt: ST_EXPECT_END_LF};
          default:   e = '{act: ACT_NONE, nxt: ST_FAILED};
        endcase
      end
      ST_NAME: begin
        case (c)
          CLS_COLON: e = '{act: ACT_NONE, nxt: ST_VALUE_LEAD};
          CLS_TOKEN: e = '{act: ACT_NAME, nxt: ST_NAME};
          default:   e = '{act: ACT_NONE, nxt: ST_FAILED};
        endcase
      end
      ST_VALUE_LEAD: begin
        case (c)
          CLS_VISIBLE, CLS_COLON, CLS_TOKEN: e = '{act: ACT_VALUE, nxt: ST_VALUE};
          CLS_BLANK: e = '{act: ACT_NONE, nxt: ST_VALUE_LEAD};
          CLS_CR:    e = '{act: ACT_NONE, nxt: ST_EXPECT_LF};
          default:   e = '{act: ACT_NONE, nxt: ST_FAILED};
        endcase
      end
      ST_VALUE: begin
        case (c)
          CLS_VISIBLE, CLS_COLON, CLS_TOKEN: e = '{act: ACT_VALUE, nxt: ST_VALUE};
          CLS_BLANK: e = '{act: ACT_HOLD_WS, nxt: ST_VALUE};
          CLS_CR:    e = '{act: ACT_NONE, nxt: ST_EXPECT_LF};
          default:   e = '{act: ACT_NONE, nxt: ST_FAILED};
        endcase
      end
      ST_EXPECT_LF: begin
        case (c)
          CLS_LF:  e = '{act: ACT_NONE, nxt: ST_LINE_END};
          default: e = '{act: ACT_NONE, nxt: ST_FAILED};
        endcase
      end
      ST_LINE_END: begin
        // token starts the next field, blank is an obs-fold, CR ends the block
        case (c)
          CLS_TOKEN: e = '{act: ACT_COMMIT, nxt: ST_NAME};
          CLS_BLANK: e = '{act: ACT_FOLD, nxt: ST_VALUE_LEAD};
          CLS_CR:    e = '{act: ACT_COMMIT, nxt: ST_EXPECT_END_LF};
          default:   e = '{act: ACT_NONE, nxt: ST_FAILED};
        endcase
      end
      ST_EXPECT_END_LF: begin
        case (c)
          CLS_LF:  e = '{act: ACT_NONE, nxt: ST_DONE};
          default: e = '{act: ACT_NONE, nxt: ST_FAILED};
        endcase
      end
      default: e = '{act: ACT_NONE, nxt: ST_FAILED};
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/http_header_field_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_header_field_tokenizer
// HTTP header field tokenizer: classifies header bytes and emits one token
// with a status per request.
// ----------------------------------------------------------------------------
// Takes one header byte per cycle while in_stall_o is low and returns one
// result per byte, in order. Each byte is classified combinationally, held in
// the two-entry request queue, then stepped by the automaton into the output
// register; sustained throughput is one byte per cycle while the output is
// not stalled, set by the automaton step. The queue absorbs a stalled output,
// so input stall rises only once two requests wait. The limit registers must
// be written with cfg_we_i only while no request is in flight; the block
// itself does not enforce this. They reset to 8190 line bytes and 100 fields.
// No clearing pass is needed after reset.
module http_header_field_tokenizer import htf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  cfg_idx_e              cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  q_item_t cls_item;
  q_item_t q_item;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  logic    push;

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  htf_front u_front (
    .item_i (in_data_i),
    .item_o (cls_item)
  );

  htf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (cls_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  htf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/htf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htf_front
// Byte classifier: class table lookup and lowercase copy of each request.
// ----------------------------------------------------------------------------
module htf_front import htf_pkg::*; (
  input  in_item_t item_i,
  output q_item_t  item_o
);

  always_comb begin
    item_o.restart  = item_i.restart;
    item_o.cls      = byte_class(item_i.octet);
    item_o.octet    = item_i.octet;
    item_o.octet_lc = to_lower(item_i.octet);
  end

endmodule

// ----- rtl/htf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htf_queue
// Short FIFO of classified requests between classifier and automaton.
// ----------------------------------------------------------------------------
module htf_queue import htf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t item_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output q_item_t item_o
);

  q_item_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue popped while empty");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not follow a lone push");

endmodule

// ----- rtl/htf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htf_back
// Field automaton: steps the parse state on each queued request, keeps the
// line and field limits, and registers one token per request.
// ----------------------------------------------------------------------------
module htf_back import htf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  cfg_idx_e              cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  q_valid_i,
  input  q_item_t               q_item_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  logic [LINE_CNT_W-1:0]  max_line_q;
  logic [FIELD_CNT_W-1:0] max_fields_q;

  state_e                 pst_q, pst_d;
  logic [LINE_CNT_W-1:0]  lbc_q, lbc_d;
  logic [FIELD_CNT_W-1:0] fc_q, fc_d;
  fcause_e                fcause_q, fcause_d;

  logic      out_valid_q;
  out_item_t out_q, out_d;

  logic   active;
  logic   line_over;
  logic   field_over;
  trans_t entry;

  // take a request whenever the output register is free or draining
  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  assign active     = (pst_q != ST_FAILED) && (pst_q != ST_DONE);
  assign line_over  = (lbc_q >= max_line_q);
  assign field_over = (fc_q >= max_fields_q);
  assign entry      = trans(pst_q, q_item_i.cls);

  // next state
  always_comb begin
    pst_d    = pst_q;
    lbc_d    = lbc_q;
    fc_d     = fc_q;
    fcause_d = fcause_q;
    if (q_pop_o) begin
      if (q_item_i.restart) begin
        pst_d    = ST_LINE_START;
        lbc_d    = '0;
        fc_d     = '0;
        fcause_d = FC_NONE;
      end else if (active) begin
        if (line_over) begin
          pst_d    = ST_FAILED;
          fcause_d = FC_LINE_LONG;
        end else begin
          lbc_d = lbc_q + 1'b1;
          if (entry.nxt == ST_FAILED) begin
            pst_d    = ST_FAILED;
            fcause_d = FC_MALFORMED;
          end else if (entry.act == ACT_COMMIT) begin
            if (field_over) begin
              pst_d    = ST_FAILED;
              fcause_d = FC_TOO_MANY;
            end else begin
              fc_d  = fc_q + 1'b1;
              lbc_d = '0;
              pst_d = entry.nxt;
            end
          end else begin
            pst_d = entry.nxt;
          end
        end
      end
    end
  end

  // token and status
  always_comb begin
    out_d            = '0;
    out_d.token_kind = TK_NONE;
    if (!q_item_i.restart && active && !line_over && entry.nxt != ST_FAILED) begin
      case (entry.act)
        ACT_COMMIT: begin
          if (!field_over) begin
            out_d.field_end = 1'b1;
            if (entry.nxt == ST_NAME) begin
              out_d.token_kind = TK_NAME;
              out_d.token_byte = q_item_i.octet_lc;
            end
          end
        end
        ACT_NAME: begin
          out_d.token_kind = TK_NAME;
          out_d.token_byte = q_item_i.octet_lc;
        end
        ACT_VALUE: begin
          out_d.token_kind = TK_VALUE;
          out_d.token_byte = q_item_i.octet;
        end
        ACT_HOLD_WS: begin
          out_d.token_kind = TK_HOLD_WS;
          out_d.token_byte = q_item_i.octet;
        end
        ACT_FOLD: begin
          out_d.token_kind = TK_FOLD;
          out_d.token_byte = FOLD_BYTE;
        end
        default: begin
          out_d.token_kind = TK_NONE;
        end
      endcase
    end
    case (pst_d)
      ST_DONE: out_d.status = STAT_COMPLETE;
      ST_FAILED: begin
        case (fcause_d)
          FC_LINE_LONG: out_d.status = STAT_LINE_LONG;
          FC_TOO_MANY:  out_d.status = STAT_TOO_MANY;
          default:      out_d.status = STAT_MALFORMED;
        endcase
      end
      default: out_d.status = STAT_IN_PROGRESS;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q   <= DEF_LINE_BYTES;
      max_fields_q <= DEF_FIELDS;
      pst_q        <= ST_LINE_START;
      lbc_q        <= '0;
      fc_q         <= '0;
      fcause_q     <= FC_NONE;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_LINE_BYTES: max_line_q   <= cfg_data_i[LINE_CNT_W-1:0];
          CFG_MAX_FIELDS:     max_fields_q <= cfg_data_i[FIELD_CNT_W-1:0];
          default:            max_line_q   <= max_line_q;
        endcase
      end
      pst_q    <= pst_d;
      lbc_q    <= lbc_d;
      fc_q     <= fc_d;
      fcause_q <= fcause_d;
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && q_item_i.restart |=>
      pst_q == ST_LINE_START && lbc_q == '0 && fc_q == '0 && fcause_q == FC_NONE)
    else $error("restart did not clear the parser");

  a_fail_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pst_q == ST_FAILED |-> fcause_q != FC_NONE)
    else $error("failed state without a cause");

  a_field_end_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.field_end |-> out_q.status == STAT_IN_PROGRESS)
    else $error("field end reported with a final status");

  a_final_ignores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && !q_item_i.restart && (pst_q == ST_FAILED || pst_q == ST_DONE) |=>
      out_q.token_kind == TK_NONE && !out_q.field_end && pst_q == $past(pst_q))
    else $error("byte not ignored after completion or failure");

endmodule
